[src/sdu_pkg.sv]
`timescale 1ns / 1ps
package sdu_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int TIME_W = 34;
    localparam int OUT_W  = 16;
    localparam int ANG_W  = 32;
    localparam int XW     = 33;
    localparam int ZW     = 34;

    function automatic logic [63:0] frac64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [63:0] q;
        r = num;
        q = '0;
        for (int i = 0; i < 64; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= den) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    localparam logic signed [ZW:0] J2000_UNIX = 35'sd946728000;

    localparam logic [63:0] L0     = frac64(64'd280460, 64'd360000);
    localparam logic [63:0] M0     = frac64(64'd3575277233, 64'd3600000000000);
    localparam logic [63:0] E0     = frac64(64'd23439291, 64'd360000000000);
    localparam logic [63:0] RATE_L = frac64(64'd36000771, 64'd1136073600000000);
    localparam logic [63:0] RATE_M = frac64(64'd3599905034, 64'd113607360000000000);
    localparam logic [63:0] RATE_E =
        (frac64(64'd130042, 64'd1136073600000000000) + 64'd5) / 10;

    localparam logic [63:0] A1_R =
        (frac64(64'd1914666471, 64'd360000000000) + 64'h8000_0000) >> 32;
    localparam logic [63:0] A2_R =
        (frac64(64'd19994643, 64'd360000000000) + 64'h8000_0000) >> 32;
    localparam logic signed [31:0] ECC_A1 = A1_R[31:0];
    localparam logic signed [31:0] ECC_A2 = A2_R[31:0];

    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [66:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > 67'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -67'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

[src/sdu_angle.sv]
`timescale 1ns / 1ps
module sdu_angle import sdu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [TIME_W-1:0] i_unix_seconds,
    output logic              o_valid,
    output logic [ANG_W-1:0]  o_lng,
    output logic [ANG_W-1:0]  o_anom,
    output logic [ANG_W-1:0]  o_eps
);

    logic signed [ZW:0]   w_s;
    logic signed [67:0]   w_pl_l, w_ph_l, w_pl_m, w_ph_m, w_pl_e, w_ph_e;
    logic [63:0]          r_pl_l, r_pl_m, r_pl_e;
    logic [31:0]          r_ph_l, r_ph_m, r_ph_e;
    logic [63:0]          w_acc_l, w_acc_m, w_acc_e;
    logic                 r_v1, r_v2;
    logic [ANG_W-1:0]     r_lng, r_anom, r_eps;

    assign w_s    = $signed({1'b0, i_unix_seconds}) - J2000_UNIX;
    assign w_pl_l = w_s * $signed({1'b0, RATE_L[31:0]});
    assign w_ph_l = w_s * $signed({1'b0, RATE_L[63:32]});
    assign w_pl_m = w_s * $signed({1'b0, RATE_M[31:0]});
    assign w_ph_m = w_s * $signed({1'b0, RATE_M[63:32]});
    assign w_pl_e = w_s * $signed({1'b0, RATE_E[31:0]});
    assign w_ph_e = w_s * $signed({1'b0, RATE_E[63:32]});

    assign w_acc_l = L0 + r_pl_l + {r_ph_l, 32'd0};
    assign w_acc_m = M0 + r_pl_m + {r_ph_m, 32'd0};
    assign w_acc_e = E0 - r_pl_e - {r_ph_e, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl_l <= w_pl_l[63:0];
            r_ph_l <= w_ph_l[31:0];
            r_pl_m <= w_pl_m[63:0];
            r_ph_m <= w_ph_m[31:0];
            r_pl_e <= w_pl_e[63:0];
            r_ph_e <= w_ph_e[31:0];
            r_lng  <= w_acc_l[63:32];
            r_anom <= w_acc_m[63:32];
            r_eps  <= w_acc_e[63:32];
        end
    end

    assign o_valid = r_v2;
    assign o_lng   = r_lng;
    assign o_anom  = r_anom;
    assign o_eps   = r_eps;

endmodule

[src/sdu_cordic.sv]
`timescale 1ns / 1ps
module sdu_cordic import sdu_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [ANG_W-1:0]      i_angle,
    input  logic [SIDE_W-1:0]     i_side,
    output logic signed [XW-1:0]  o_cos,
    output logic signed [XW-1:0]  o_sin,
    output logic [SIDE_W-1:0]     o_side
);

    logic signed [XW-1:0] r_x [0:STAGES];
    logic signed [XW-1:0] r_y [0:STAGES];
    logic signed [ZW-1:0] r_z [0:STAGES];
    logic                 r_f [0:STAGES];
    logic [SIDE_W-1:0]    r_sd [0:STAGES];
    logic signed [ZW-1:0] w_a;
    logic signed [ZW-1:0] n_z0;
    logic                 n_f0;
    logic signed [XW-1:0] r_c, r_s;
    logic [SIDE_W-1:0]    r_so;

    assign w_a = ZW'($signed(i_angle));

    always_comb begin
        n_z0 = w_a;
        n_f0 = 1'b0;
        if (w_a > 34'sd1073741824) begin
            n_z0 = w_a - 34'sd2147483648;
            n_f0 = 1'b1;
        end else if (w_a < -34'sd1073741824) begin
            n_z0 = w_a + 34'sd2147483648;
            n_f0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd[0] <= '0;
        end else if (i_en) begin
            r_sd[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_f[0] <= n_f0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = $signed({2'b00, ATAN_TURN[i]});
        logic signed [XW-1:0] n_x, n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            if (!r_z[i][ZW-1]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ATAN_I;
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ATAN_I;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[i+1] <= '0;
            end else if (i_en) begin
                r_sd[i+1] <= r_sd[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1] <= n_x;
                r_y[i+1] <= n_y;
                r_z[i+1] <= n_z;
                r_f[i+1] <= r_f[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_so <= '0;
        end else if (i_en) begin
            r_so <= r_sd[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= r_f[STAGES] ? -r_x[STAGES] : r_x[STAGES];
            r_s <= r_f[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        end
    end

    assign o_cos  = r_c;
    assign o_sin  = r_s;
    assign o_side = r_so;

endmodule

[src/sdu_ecc.sv]
`timescale 1ns / 1ps
module sdu_ecc import sdu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_sin_m,
    input  logic signed [XW-1:0] i_sin_2m,
    input  logic [ANG_W-1:0]     i_lng,
    input  logic [ANG_W-1:0]     i_eps,
    output logic                 o_valid,
    output logic [ANG_W-1:0]     o_lam,
    output logic [ANG_W-1:0]     o_eps
);

    logic signed [64:0] r_p1, r_p2;
    logic signed [65:0] w_sum;
    logic [ANG_W-1:0]   r_lng, r_eps1, r_lam, r_eps2;
    logic               r_v1, r_v2;

    assign w_sum = 66'(r_p1) + 66'(r_p2) + 66'sd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= i_sin_m * ECC_A1;
            r_p2   <= i_sin_2m * ECC_A2;
            r_lng  <= i_lng;
            r_eps1 <= i_eps;
            r_lam  <= r_lng + w_sum[61:30];
            r_eps2 <= r_eps1;
        end
    end

    assign o_valid = r_v2;
    assign o_lam   = r_lam;
    assign o_eps   = r_eps2;

endmodule

[src/sun_direction_unit_vector_core.sv]
`timescale 1ns / 1ps
// Earth-to-Sun unit vector in the equatorial frame from a UTC Unix time, after the
// low-precision solar model. One transfer is taken per clock while o_stall is low. The
// result is set by two pipelined CORDIC passes in series (mean anomaly first, then
// ecliptic longitude and obliquity). A two-entry output buffer holds results during
// a stall, and o_stall rises only when it is full. Outputs are signed with
// OUT_FRAC_BITS fraction bits, saturated.
module sun_direction_unit_vector_core import sdu_pkg::*; #(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [TIME_W-1:0]       i_unix_seconds,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_sun_x,
    output logic signed [OUT_W-1:0] o_sun_y,
    output logic signed [OUT_W-1:0] o_sun_z
);

    localparam int KX = 30 - OUT_FRAC_BITS;
    localparam int KP = 60 - OUT_FRAC_BITS;

    logic                 w_en;
    logic                 w_av;
    logic [ANG_W-1:0]     w_lng, w_anom, w_eps;
    logic signed [XW-1:0] w_cm, w_sm, w_c2m, w_s2m;
    logic [ANG_W:0]       w_side_m;
    logic [ANG_W:0]       w_side_2m;
    logic                 w_ev;
    logic [ANG_W-1:0]     w_lam, w_eps2;
    logic signed [XW-1:0] w_cl, w_sl, w_ce, w_se;
    logic                 w_vl, w_ve;
    logic                 r_pv;
    logic signed [XW-1:0] r_cl;
    logic signed [65:0]   r_py, r_pz;
    logic signed [66:0]   w_xr, w_yr, w_zr;
    logic signed [OUT_W-1:0] w_x, w_y, w_z;
    logic                 r_ov, r_sv;
    logic signed [OUT_W-1:0] r_ox, r_oy, r_oz, r_sx, r_sy, r_sz;

    assign w_en    = !r_sv;
    assign o_stall = r_sv;

    sdu_angle u_angle (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_unix_seconds (i_unix_seconds),
        .o_valid        (w_av),
        .o_lng          (w_lng),
        .o_anom         (w_anom),
        .o_eps          (w_eps)
    );

    sdu_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(ANG_W + 1)) u_cordic_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_angle (w_anom),
        .i_side  ({w_av, w_lng}),
        .o_cos   (w_cm),
        .o_sin   (w_sm),
        .o_side  (w_side_m)
    );

    sdu_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(ANG_W + 1)) u_cordic_2m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_angle ({w_anom[ANG_W-2:0], 1'b0}),
        .i_side  ({w_av, w_eps}),
        .o_cos   (w_c2m),
        .o_sin   (w_s2m),
        .o_side  (w_side_2m)
    );

    sdu_ecc u_ecc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_side_m[ANG_W] & w_side_2m[ANG_W] & (w_cm == w_cm) & (w_c2m == w_c2m)),
        .i_sin_m  (w_sm),
        .i_sin_2m (w_s2m),
        .i_lng    (w_side_m[ANG_W-1:0]),
        .i_eps    (w_side_2m[ANG_W-1:0]),
        .o_valid  (w_ev),
        .o_lam    (w_lam),
        .o_eps    (w_eps2)
    );

    sdu_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_angle (w_lam),
        .i_side  (w_ev),
        .o_cos   (w_cl),
        .o_sin   (w_sl),
        .o_side  (w_vl)
    );

    sdu_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_angle (w_eps2),
        .i_side  (w_ev),
        .o_cos   (w_ce),
        .o_sin   (w_se),
        .o_side  (w_ve)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= w_vl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cl <= w_cl;
            r_py <= w_ce * w_sl;
            r_pz <= w_se * w_sl;
        end
    end

    if (KX > 0) begin : g_xr
        assign w_xr = (67'(r_cl) + (67'sd1 <<< (KX - 1))) >>> KX;
    end else begin : g_xn
        assign w_xr = 67'(r_cl);
    end
    assign w_yr = (67'(r_py) + (67'sd1 <<< (KP - 1))) >>> KP;
    assign w_zr = (67'(r_pz) + (67'sd1 <<< (KP - 1))) >>> KP;

    assign w_x = sat16(w_xr);
    assign w_y = sat16(w_yr);
    assign w_z = sat16(w_zr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_ov && i_stall) begin
            if (w_en && r_pv) begin
                r_sv <= 1'b1;
            end
        end else if (r_sv) begin
            r_ov <= 1'b1;
            r_sv <= 1'b0;
        end else begin
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && i_stall) begin
            if (!r_sv) begin
                r_sx <= w_x;
                r_sy <= w_y;
                r_sz <= w_z;
            end
        end else if (r_sv) begin
            r_ox <= r_sx;
            r_oy <= r_sy;
            r_oz <= r_sz;
        end else begin
            r_ox <= w_x;
            r_oy <= w_y;
            r_oz <= w_z;
        end
    end

    assign o_valid = r_ov;
    assign o_sun_x = r_ox;
    assign o_sun_y = r_oy;
    assign o_sun_z = r_oz;

    a_valid_m_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_side_m[ANG_W] == w_side_2m[ANG_W])
        else $error("anomaly CORDIC valid bits disagree");

    a_valid_l_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vl == w_ve)
        else $error("longitude and obliquity CORDIC valid bits disagree");

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("buffered result without a result on the output");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_stall) |=> (r_ov && !r_sv))
        else $error("buffered result was not moved to the output");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import sdu_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_sun_vec;

    typedef struct {
        longint c;
        longint s;
    } t_trig;

    localparam int FRAC_BITS = OUT_FRAC_BITS_DEF;
    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int LATENCY   = 2 * STAGES + 10;
    localparam longint unsigned EPOCH_J2000 = 64'd946728000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [TIME_W-1:0]       i_unix_seconds;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [OUT_W-1:0] o_sun_x;
    logic signed [OUT_W-1:0] o_sun_y;
    logic signed [OUT_W-1:0] o_sun_z;

    t_sun_vec expected_vectors[$];
    int       mismatch_count;
    bit       tx_idle_en;
    bit       rx_idle_en;
    int       rx_hold_cycles;

    longint unsigned off_lng, off_anom, off_eps, rate_lng, rate_anom, rate_eps;
    longint          ecc_a1, ecc_a2;
    longint          arctan_tab[32];

    sun_direction_unit_vector_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_unix_seconds (i_unix_seconds),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sun_x        (o_sun_x),
        .o_sun_y        (o_sun_y),
        .o_sun_z        (o_sun_z)
    );

    // Rounded num/den as a 64-bit fraction of a turn, ties rounded up.
    function automatic longint unsigned turn_frac(longint unsigned num, longint unsigned den);
        logic [131:0] n;
        logic [131:0] d;
        n = ({68'd0, num} << 65) + {68'd0, den};
        d = {68'd0, den} << 1;
        return 64'(n / d);
    endfunction

    function automatic longint round_down_shift(longint v, int k);
        if (k <= 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp16(longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic t_trig rotate(logic [31:0] ang);
        t_trig  r;
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > (64'sd1 <<< 30)) begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - arctan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + arctan_tab[i];
            end
            x = nx;
        end
        r.c = flip ? -x : x;
        r.s = flip ? -y : y;
        return r;
    endfunction

    function automatic t_sun_vec sun_direction(logic [TIME_W-1:0] t);
        t_sun_vec        v;
        longint unsigned since;
        logic [63:0]     acc;
        logic [31:0]     lng;
        logic [31:0]     anom;
        logic [31:0]     obl;
        logic [31:0]     lam;
        t_trig           m1;
        t_trig           m2;
        t_trig           le;
        t_trig           ob;
        longint          corr;
        since = {30'd0, t} - EPOCH_J2000;
        acc  = off_lng + since * rate_lng;
        lng  = acc[63:32];
        acc  = off_anom + since * rate_anom;
        anom = acc[63:32];
        acc  = off_eps - since * rate_eps;
        obl  = acc[63:32];
        m1   = rotate(anom);
        m2   = rotate(anom << 1);
        corr = round_down_shift(ecc_a1 * m1.s + ecc_a2 * m2.s, 30);
        lam  = lng + corr[31:0];
        le   = rotate(lam);
        ob   = rotate(obl);
        v.x  = clamp16(round_down_shift(le.c, 30 - FRAC_BITS));
        v.y  = clamp16(round_down_shift(ob.c * le.s, 60 - FRAC_BITS));
        v.z  = clamp16(round_down_shift(ob.s * le.s, 60 - FRAC_BITS));
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_time(logic [TIME_W-1:0] t);
        @(negedge i_clk);
        while (tx_idle_en && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_unix_seconds <= t;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        expected_vectors.push_back(sun_direction(t));
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        logic [TIME_W-1:0] t;
        case ($urandom_range(3))
            0: t = {2'($urandom_range(3)), $urandom()};
            1: t = TIME_W'(64'd946728000 + $urandom_range(1800000000));
            2: t = TIME_W'($urandom_range(1999999999));
            default: t = TIME_W'(64'd17179869183 - $urandom_range(100000000));
        endcase
        return t;
    endfunction

    task automatic test_directed();
        logic [TIME_W-1:0] pts[$];
        pts = '{34'd0, 34'h3_FFFF_FFFF, 34'd946728000, 34'd946727999, 34'd946728001,
                34'h2_AAAA_AAAA, 34'h1_5555_5555, 34'd1, 34'h2_0000_0000,
                34'h1_FFFF_FFFF, 34'd1710979200, 34'd1718928000, 34'd1734825600,
                34'd1727049600, 34'd4102444800, 34'd10000000000, 34'd473385600};
        foreach (pts[i]) begin
            send_time(pts[i]);
        end
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            tx_idle_en = (i < n / 3) || (i >= n / 2);
            rx_idle_en = tx_idle_en;
            send_time(random_time());
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_hold_cycles = 200;
        for (int i = 0; i < 120; i++) begin
            send_time(random_time());
        end
        tx_idle_en = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= rx_idle_en && ($urandom_range(99) < 24);
        end
    end

    always @(posedge i_clk) begin
        t_sun_vec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_vectors.size() == 0) begin
                report_mismatch("unexpected transfer, x", o_sun_x, 0);
            end else begin
                want = expected_vectors.pop_front();
                if (o_sun_x !== want.x) report_mismatch("sun_x", o_sun_x, want.x);
                if (o_sun_y !== want.y) report_mismatch("sun_y", o_sun_y, want.y);
                if (o_sun_z !== want.z) report_mismatch("sun_z", o_sun_z, want.z);
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("sun_direction_unit_vector_core test failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_unix_seconds = '0;
        mismatch_count = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_hold_cycles = 0;
        arctan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                       83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                       81, 41, 20, 10, 5, 3, 1, 1, 0};
        off_lng   = turn_frac(280460, 360000);
        off_anom  = turn_frac(64'd3575277233, 64'd3600000000000);
        off_eps   = turn_frac(23439291, 64'd360000000000);
        rate_lng  = turn_frac(36000771, 64'd1136073600000000);
        rate_anom = turn_frac(64'd3599905034, 64'd113607360000000000);
        rate_eps  = (turn_frac(130042, 64'd1136073600000000000) + 5) / 10;
        ecc_a1    = longint'((turn_frac(64'd1914666471, 64'd360000000000)
                              + 64'h8000_0000) >> 32);
        ecc_a2    = longint'((turn_frac(19994643, 64'd360000000000)
                              + 64'h8000_0000) >> 32);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(560);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_vectors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("sun_direction_unit_vector_core test passed");
        end else begin
            $display("sun_direction_unit_vector_core test failed");
        end
        $finish;
    end
endmodule
